// ===== sv/sftr_pkg.sv =====
package sftr_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_HEIGHT  = 512;
   localparam int STORE_BYTES = (MAX_WIDTH / 8) * MAX_HEIGHT;
   localparam int ADDR_W      = $clog2(STORE_BYTES);
   localparam int PITCH_W     = $clog2(MAX_WIDTH / 8) + 1;
   localparam int COL_W       = $clog2(MAX_WIDTH) + 1;
   localparam int ROW_W       = $clog2(MAX_HEIGHT) + 1;

   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_PANEL_WIDTH  = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PANEL_HEIGHT = 8'd1;

   localparam logic [10:0] PANEL_WIDTH_RESET  = 11'd800;
   localparam logic [9:0]  PANEL_HEIGHT_RESET = 10'd480;

   localparam logic [2:0] OP_BEGIN   = 3'd0;
   localparam logic [2:0] OP_CHAR    = 3'd1;
   localparam logic [2:0] OP_FILL    = 3'd2;
   localparam logic [2:0] OP_PATTERN = 3'd3;
   localparam logic [2:0] OP_READ    = 3'd4;

   localparam logic [7:0] CHAR_NEWLINE = 8'd10;

   localparam logic [7:0] BYTE_WHITE  = 8'h00;
   localparam logic [7:0] BYTE_BLACK  = 8'hFF;
   localparam logic [7:0] BYTE_STRIPE = 8'hAA;
   localparam logic [7:0] BYTE_HIGH   = 8'hF0;
   localparam logic [7:0] BYTE_LOW    = 8'h0F;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_PIX_RD = 5'b00010,
      ST_PIX_WR = 5'b00100,
      ST_SWEEP  = 5'b01000,
      ST_RDATA  = 5'b10000
   } state_type;

   localparam logic [7:0] DIGIT_FONT [10][5] = '{
      '{8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E}, '{8'h00, 8'h42, 8'h7F, 8'h40, 8'h00},
      '{8'h42, 8'h61, 8'h51, 8'h49, 8'h46}, '{8'h21, 8'h41, 8'h45, 8'h4B, 8'h31},
      '{8'h18, 8'h14, 8'h12, 8'h7F, 8'h10}, '{8'h27, 8'h45, 8'h45, 8'h45, 8'h39},
      '{8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30}, '{8'h01, 8'h71, 8'h09, 8'h05, 8'h03},
      '{8'h36, 8'h49, 8'h49, 8'h49, 8'h36}, '{8'h06, 8'h49, 8'h49, 8'h29, 8'h1E}
   };

   localparam logic [7:0] LETTER_FONT [26][5] = '{
      '{8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E}, '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h36},
      '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h22}, '{8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C},
      '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h41}, '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h01},
      '{8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A}, '{8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F},
      '{8'h00, 8'h41, 8'h7F, 8'h41, 8'h00}, '{8'h20, 8'h40, 8'h41, 8'h3F, 8'h01},
      '{8'h7F, 8'h08, 8'h14, 8'h22, 8'h41}, '{8'h7F, 8'h40, 8'h40, 8'h40, 8'h40},
      '{8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F}, '{8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F},
      '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E}, '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h06},
      '{8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E}, '{8'h7F, 8'h09, 8'h19, 8'h29, 8'h46},
      '{8'h46, 8'h49, 8'h49, 8'h49, 8'h31}, '{8'h01, 8'h01, 8'h7F, 8'h01, 8'h01},
      '{8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F}, '{8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F},
      '{8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F}, '{8'h63, 8'h14, 8'h08, 8'h14, 8'h63},
      '{8'h03, 8'h04, 8'h78, 8'h04, 8'h03}, '{8'h61, 8'h51, 8'h49, 8'h45, 8'h43}
   };

   // space, question, dash, dot, colon, slash, percent, underscore
   localparam logic [7:0] SYMBOL_FONT [8][5] = '{
      '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, '{8'h02, 8'h01, 8'h51, 8'h09, 8'h06},
      '{8'h08, 8'h08, 8'h08, 8'h08, 8'h08}, '{8'h00, 8'h60, 8'h60, 8'h00, 8'h00},
      '{8'h00, 8'h36, 8'h36, 8'h00, 8'h00}, '{8'h20, 8'h10, 8'h08, 8'h04, 8'h02},
      '{8'h62, 8'h64, 8'h08, 8'h13, 8'h23}, '{8'h40, 8'h40, 8'h40, 8'h40, 8'h40}
   };

   function automatic logic [7:0] glyph_col(input logic [7:0] code, input logic [2:0] col);
      logic [7:0] c;
      logic [7:0] d;
      logic [7:0] l;
      logic [7:0] g;
      c = code;
      if (c >= 8'h61 && c <= 8'h7A) begin
         c = c - 8'd32;
      end
      d = c - 8'h30;
      l = c - 8'h41;
      if (c >= 8'h30 && c <= 8'h39) begin
         g = DIGIT_FONT[d[3:0]][col];
      end else if (c >= 8'h41 && c <= 8'h5A) begin
         g = LETTER_FONT[l[4:0]][col];
      end else begin
         case (c)
            8'h20:   g = SYMBOL_FONT[3'd0][col];
            8'h2D:   g = SYMBOL_FONT[3'd2][col];
            8'h2E:   g = SYMBOL_FONT[3'd3][col];
            8'h3A:   g = SYMBOL_FONT[3'd4][col];
            8'h2F:   g = SYMBOL_FONT[3'd5][col];
            8'h25:   g = SYMBOL_FONT[3'd6][col];
            8'h5F:   g = SYMBOL_FONT[3'd7][col];
            default: g = SYMBOL_FONT[3'd1][col];
         endcase
      end
      return g;
   endfunction

endpackage

// ===== sv/sftr_if.sv =====
interface sftr_req_if;
   import sftr_pkg::*;
   logic        valid;
   logic        ready;
   logic [2:0]  opcode;
   logic [15:0] start_x;
   logic [15:0] start_y;
   logic [15:0] text_size;
   logic [7:0]  char_code;
   logic        fill_white;
   logic [15:0] read_address;
   modport source (output valid, opcode, start_x, start_y, text_size, char_code,
                   fill_white, read_address, input ready);
   modport sink (input valid, opcode, start_x, start_y, text_size, char_code,
                 fill_white, read_address, output ready);
endinterface

interface sftr_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] region_w;
   logic [15:0] region_h;
   logic [7:0]  read_data;
   modport source (output valid, region_w, region_h, read_data, input ready);
   modport sink (input valid, region_w, region_h, read_data, output ready);
endinterface

interface sftr_csr_if;
   import sftr_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/scaled_font_text_rasterizer_unit.sv =====
// Text renderer into a 64 KiB one-bit-per-pixel frame store. After reset the
// block clears the store, one byte a cycle, before it takes its first item.
// Begin text, newline and unused opcodes answer straight from idle, read byte
// by way of a read state. A character draws 35*s*s pixels (s = scale 1..4)
// by read-modify-write through the store's read port and write port, each
// pixel read in a read state, then written in a write state. Fill and test
// pattern sweep all 65536 bytes, one a cycle. One item is in work at a time;
// the result is held until taken, and the next item is accepted once it is.
module scaled_font_text_rasterizer_unit (
   input logic clock,
   input logic reset,
   sftr_req_if.sink   req_bus,
   sftr_rsp_if.source rsp_bus,
   sftr_csr_if.sink   csr_bus
);
   import sftr_pkg::*;

   state_type           state_ff, state_in;
   logic [10:0]         pw_ff, pw_in;
   logic [9:0]          ph_ff, ph_in;
   logic [15:0]         cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [15:0]         org_x_ff, org_x_in, org_y_ff, org_y_in;
   logic [2:0]          scale_ff, scale_in;
   logic [15:0]         area_w_ff, area_w_in, area_h_ff, area_h_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [7:0]          rdata_ff, rdata_in;
   logic [7:0]          code_ff, code_in;
   logic [1:0]          dx_ff, dx_in, dy_ff, dy_in;
   logic [2:0]          gr_ff, gr_in, gc_ff, gc_in;
   logic [ADDR_W-1:0]   paddr_ff, paddr_in;
   logic [7:0]          pmask_ff, pmask_in;
   logic                pblack_ff, pblack_in, phit_ff, phit_in;
   logic [ADDR_W-1:0]   scnt_ff, scnt_in;
   logic                spat_ff, spat_in, sresp_ff, sresp_in;
   logic [7:0]          sfill_ff, sfill_in;
   logic [PITCH_W-1:0]  scol_ff, scol_in;
   logic [ROW_W-1:0]    srow_ff, srow_in;

   logic [7:0]          mem [STORE_BYTES];
   logic [7:0]          mem_q;
   logic                mem_we;
   logic [ADDR_W-1:0]   mem_wa, mem_ra;
   logic [7:0]          mem_wd;

   logic [COL_W-1:0]    eff_w;
   logic [ROW_W-1:0]    eff_h;
   logic [PITCH_W-1:0]  pitch;
   logic [4:0]          xo, yo;
   logic [15:0]         px, py;
   logic [7:0]          gbits;
   logic [16:0]         prod;
   logic [15:0]         pix_addr;
   logic                pix_hit, pix_last;
   logic [2:0]          new_scale, scale_m1;
   logic [11:0]         row3;
   logic [7:0]          band;
   logic                req_acc;

   assign eff_w = (pw_ff > 11'(MAX_WIDTH)) ? COL_W'(MAX_WIDTH)
                                           : {pw_ff[COL_W-1:3], 3'b000};
   assign eff_h = (ph_ff > 10'(MAX_HEIGHT)) ? ROW_W'(MAX_HEIGHT) : ROW_W'(ph_ff);
   assign pitch = eff_w[COL_W-1:3];

   assign xo       = {2'b00, gc_ff} * {2'b00, scale_ff} + {3'b000, dx_ff};
   assign yo       = {2'b00, gr_ff} * {2'b00, scale_ff} + {3'b000, dy_ff};
   assign px       = cur_x_ff + {11'd0, xo};
   assign py       = cur_y_ff + {11'd0, yo};
   assign gbits    = glyph_col(code_ff, gc_ff);
   assign pix_hit  = ({5'd0, eff_w} > {1'b0, px}) && ({6'd0, eff_h} > py);
   assign prod     = {8'd0, py[ROW_W-2:0]} * {9'd0, pitch};
   assign pix_addr = prod[15:0] + {9'd0, px[COL_W-2:3]};
   assign scale_m1 = scale_ff - 3'd1;
   assign pix_last = (gc_ff == 3'd4) && (gr_ff == 3'd6) &&
                     ({1'b0, dx_ff} == scale_m1) && ({1'b0, dy_ff} == scale_m1);

   assign new_scale = (req_bus.text_size >= 16'd32) ? 3'd4 :
                      (req_bus.text_size >= 16'd24) ? 3'd3 :
                      (req_bus.text_size >= 16'd16) ? 3'd2 : 3'd1;

   assign row3 = {2'b00, srow_ff} * 12'd3 + 12'd3;
   always_comb begin
      if (pitch == '0 || srow_ff >= eff_h) begin
         band = BYTE_WHITE;
      end else if (row3 <= {2'b00, eff_h}) begin
         band = scol_ff[0] ? BYTE_WHITE : BYTE_BLACK;
      end else if (row3 <= {1'b0, eff_h, 1'b0}) begin
         band = BYTE_STRIPE;
      end else begin
         band = scol_ff[0] ? BYTE_HIGH : BYTE_LOW;
      end
   end

   assign req_bus.ready   = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign req_acc         = req_bus.valid && req_bus.ready;
   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.region_w  = area_w_ff;
   assign rsp_bus.region_h  = area_h_ff;
   assign rsp_bus.read_data = rdata_ff;
   assign csr_bus.ready   = 1'b1;

   assign mem_ra = (state_ff == ST_PIX_RD) ? pix_addr : req_bus.read_address;

   always_comb begin
      mem_we = 1'b0;
      mem_wa = scnt_ff;
      mem_wd = spat_ff ? band : sfill_ff;
      if (state_ff == ST_SWEEP) begin
         mem_we = 1'b1;
      end else if (state_ff == ST_PIX_WR && phit_ff) begin
         mem_we = 1'b1;
         mem_wa = paddr_ff;
         mem_wd = pblack_ff ? (mem_q | pmask_ff) : (mem_q & ~pmask_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      mem_q <= mem[mem_ra];
   end

   always_comb begin
      state_in     = state_ff;
      pw_in        = pw_ff;
      ph_in        = ph_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      org_x_in     = org_x_ff;
      org_y_in     = org_y_ff;
      scale_in     = scale_ff;
      area_w_in    = area_w_ff;
      area_h_in    = area_h_ff;
      rsp_valid_in = rsp_valid_ff;
      rdata_in     = rdata_ff;
      code_in      = code_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      gr_in        = gr_ff;
      gc_in        = gc_ff;
      paddr_in     = paddr_ff;
      pmask_in     = pmask_ff;
      pblack_in    = pblack_ff;
      phit_in      = phit_ff;
      scnt_in      = scnt_ff;
      spat_in      = spat_ff;
      sresp_in     = sresp_ff;
      sfill_in     = sfill_ff;
      scol_in      = scol_ff;
      srow_in      = srow_ff;

      if (csr_bus.valid) begin
         if (csr_bus.index == CSR_PANEL_WIDTH) begin
            pw_in = csr_bus.data[10:0];
         end else if (csr_bus.index == CSR_PANEL_HEIGHT) begin
            ph_in = csr_bus.data[9:0];
         end
      end

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               rdata_in = 8'd0;
               case (req_bus.opcode)
                  OP_BEGIN: begin
                     org_x_in     = req_bus.start_x;
                     org_y_in     = req_bus.start_y;
                     cur_x_in     = req_bus.start_x;
                     cur_y_in     = req_bus.start_y;
                     scale_in     = new_scale;
                     area_w_in    = 16'd0;
                     area_h_in    = {10'd0, new_scale, 3'b000};
                     rsp_valid_in = 1'b1;
                  end
                  OP_CHAR: begin
                     if (req_bus.char_code == CHAR_NEWLINE) begin
                        cur_x_in     = org_x_ff;
                        cur_y_in     = cur_y_ff + {10'd0, scale_ff, 3'b000};
                        area_h_in    = area_h_ff + {10'd0, scale_ff, 3'b000};
                        rsp_valid_in = 1'b1;
                     end else begin
                        code_in  = req_bus.char_code;
                        dx_in    = 2'd0;
                        dy_in    = 2'd0;
                        gr_in    = 3'd0;
                        gc_in    = 3'd0;
                        state_in = ST_PIX_RD;
                     end
                  end
                  OP_FILL: begin
                     sfill_in = req_bus.fill_white ? BYTE_WHITE : BYTE_BLACK;
                     spat_in  = 1'b0;
                     sresp_in = 1'b1;
                     scnt_in  = '0;
                     state_in = ST_SWEEP;
                  end
                  OP_PATTERN: begin
                     spat_in   = 1'b1;
                     sresp_in  = 1'b1;
                     scnt_in   = '0;
                     scol_in   = '0;
                     srow_in   = '0;
                     area_w_in = {5'd0, pw_ff};
                     area_h_in = {6'd0, ph_ff};
                     state_in  = ST_SWEEP;
                  end
                  OP_READ: begin
                     state_in = ST_RDATA;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_PIX_RD: begin
            paddr_in  = pix_addr;
            pmask_in  = 8'h80 >> px[2:0];
            pblack_in = gbits[gr_ff];
            phit_in   = pix_hit;
            state_in  = ST_PIX_WR;
         end
         ST_PIX_WR: begin
            if (pix_last) begin
               cur_x_in     = cur_x_ff + {11'd0, scale_ff, 2'b00} + {12'd0, scale_ff, 1'b0};
               area_w_in    = cur_x_in - org_x_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_PIX_RD;
               if ({1'b0, dx_ff} != scale_m1) begin
                  dx_in = dx_ff + 2'd1;
               end else begin
                  dx_in = 2'd0;
                  if ({1'b0, dy_ff} != scale_m1) begin
                     dy_in = dy_ff + 2'd1;
                  end else begin
                     dy_in = 2'd0;
                     if (gr_ff != 3'd6) begin
                        gr_in = gr_ff + 3'd1;
                     end else begin
                        gr_in = 3'd0;
                        gc_in = gc_ff + 3'd1;
                     end
                  end
               end
            end
         end
         ST_SWEEP: begin
            scnt_in = scnt_ff + 1'b1;
            if (pitch != '0 && scol_ff + 1'b1 == pitch) begin
               scol_in = '0;
               if (srow_ff < eff_h) begin
                  srow_in = srow_ff + 1'b1;
               end
            end else begin
               scol_in = scol_ff + 1'b1;
            end
            if (scnt_ff == '1) begin
               rsp_valid_in = sresp_ff;
               state_in     = ST_IDLE;
            end
         end
         ST_RDATA: begin
            rdata_in     = mem_q;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         pw_ff        <= PANEL_WIDTH_RESET;
         ph_ff        <= PANEL_HEIGHT_RESET;
         cur_x_ff     <= 16'd0;
         cur_y_ff     <= 16'd0;
         org_x_ff     <= 16'd0;
         org_y_ff     <= 16'd0;
         scale_ff     <= 3'd1;
         area_w_ff    <= 16'd0;
         area_h_ff    <= 16'd8;
         rsp_valid_ff <= 1'b0;
         scnt_ff      <= '0;
         spat_ff      <= 1'b0;
         sresp_ff     <= 1'b0;
         sfill_ff     <= BYTE_WHITE;
      end else begin
         state_ff     <= state_in;
         pw_ff        <= pw_in;
         ph_ff        <= ph_in;
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         org_x_ff     <= org_x_in;
         org_y_ff     <= org_y_in;
         scale_ff     <= scale_in;
         area_w_ff    <= area_w_in;
         area_h_ff    <= area_h_in;
         rsp_valid_ff <= rsp_valid_in;
         scnt_ff      <= scnt_in;
         spat_ff      <= spat_in;
         sresp_ff     <= sresp_in;
         sfill_ff     <= sfill_in;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff  <= rdata_in;
      code_ff   <= code_in;
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      gr_ff     <= gr_in;
      gc_ff     <= gc_in;
      paddr_ff  <= paddr_in;
      pmask_ff  <= pmask_in;
      pblack_ff <= pblack_in;
      phit_ff   <= phit_in;
      scol_ff   <= scol_in;
      srow_ff   <= srow_in;
   end

   a_onehot_state: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("state not one-hot");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !req_bus.ready) else $error("item accepted while busy");

   a_rsp_only_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == ST_IDLE) else $error("result shown while busy");

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_PIX_WR || state_ff == ST_SWEEP))
      else $error("store written outside a write state");

endmodule
